// ----- sv/wdt2_pkg.sv -----
// wdt2_pkg: shared types, codes and constants for the two-stage overflow watchdog.
// No dependencies; imported by every module of the block except wdt2_checker.
package wdt2_pkg;

    localparam int unsigned COUNT_W = 12;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned DATA_W  = 8;

    localparam logic [DATA_W-1:0] KEY_FIRST  = 8'h5A;
    localparam logic [DATA_W-1:0] KEY_SECOND = 8'hA5;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [DATA_W-1:0] write_data;
        logic              low_speed_tap;
    } item_t;

    typedef struct packed {
        logic read_data;
        logic nmi_request;
        logic system_reset;
    } result_t;

    // Timeout of 2^(2*mode+5) counted ticks.
    function automatic logic [COUNT_W-1:0] timeout_limit(input logic [MODE_W-1:0] mode);
        logic [COUNT_W-1:0] lim;
        case (mode)
            2'd0:    lim = 12'd32;
            2'd1:    lim = 12'd128;
            2'd2:    lim = 12'd512;
            default: lim = 12'd2048;
        endcase
        return lim;
    endfunction

endpackage

// ----- sv/watchdog_two_stage_overflow_core.sv -----
// watchdog_two_stage_overflow_core: top level of the two-stage overflow watchdog.
// Depends on wdt2_pkg, wdt2_in_stage, wdt2_engine, wdt2_out_stage.
//
// Usage:
//   Input channel (in_valid/in_stall) carries func, write_data, low_speed_tap.
//   func 0 is a tick (counts when low_speed_tap is set), 1 writes the control
//   byte, 2 reads the phase bit. Every transaction yields exactly one result
//   on the output channel (out_valid/out_stall): read_data, nmi_request,
//   system_reset.
//   Path: an accepted input passes the input register, then the result register,
//   and out_valid rises once it reaches the result register. Throughput: one
//   transaction per cycle while out_stall does not hold a result; the state
//   update is a single 12-bit increment and compare between the two registers.
//   cfg_write_en/cfg_write_data set timeout_mode (timeout 2^(2*mode+5) ticks);
//   write only while no transaction is in flight.
//   Reset (rst_n low, asynchronous): counter, control byte, phase and overflow
//   mark clear, timeout_mode returns to 2, both channels empty. A result with
//   system_reset set returns the same state, but the channels keep their contents.
//   When out_stall holds a result, the input register keeps the next
//   transaction and in_stall rises until the result is taken.
module watchdog_two_stage_overflow_core
    import wdt2_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic [DATA_W-1:0] write_data,
    input  logic              low_speed_tap,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              read_data,
    output logic              nmi_request,
    output logic              system_reset,
    input  logic              cfg_write_en,
    input  logic [MODE_W-1:0] cfg_write_data
);

    item_t   item_in, item_s1;
    result_t result_c, result_q;
    logic    s1_valid, out_ready, advance, in_accept;

    assign item_in.func          = func_t'(func);
    assign item_in.write_data    = write_data;
    assign item_in.low_speed_tap = low_speed_tap;

    assign advance   = s1_valid && out_ready;
    assign in_stall  = s1_valid && !out_ready;
    assign in_accept = in_valid && !in_stall;

    wdt2_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_accept),
        .drain    (advance),
        .item_in  (item_in),
        .valid    (s1_valid),
        .item_out (item_s1)
    );

    wdt2_engine u_eng (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (advance),
        .item           (item_s1),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .result         (result_c)
    );

    wdt2_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s1_valid),
        .stall      (out_stall),
        .result_in  (result_c),
        .valid      (out_valid),
        .ready      (out_ready),
        .result_out (result_q)
    );

    assign read_data    = result_q.read_data;
    assign nmi_request  = result_q.nmi_request;
    assign system_reset = result_q.system_reset;

endmodule

// ----- sv/wdt2_in_stage.sv -----
// wdt2_in_stage: input register holding one accepted transaction.
// Depends on wdt2_pkg (item_t).
module wdt2_in_stage
    import wdt2_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  logic  drain,
    input  item_t item_in,
    output logic  valid,
    output item_t item_out
);

    logic  valid_reg;
    item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (drain)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

// ----- sv/wdt2_engine.sv -----
// wdt2_engine: watchdog state (counter, control byte, phase, overflow mark, mode)
// and the single-pass update for one transaction. Depends on wdt2_pkg.
module wdt2_engine
    import wdt2_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  item_t             item,
    input  logic              cfg_write_en,
    input  logic [MODE_W-1:0] cfg_write_data,
    output result_t           result
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [DATA_W-1:0]  ctrl_reg, ctrl_next;
    logic               phase_reg, phase_next;
    logic               ovf_reg, ovf_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [COUNT_W-1:0] count_inc;

    assign count_inc = count_reg + 12'd1;

    always_comb
    begin
        count_next = count_reg;
        ctrl_next  = ctrl_reg;
        phase_next = phase_reg;
        ovf_next   = ovf_reg;
        mode_next  = cfg_write_en ? cfg_write_data : mode_reg;
        result     = '0;
        case (item.func)
            FUNC_TICK:
            begin
                if (item.low_speed_tap)
                begin
                    count_next = count_inc;
                    if (count_inc >= timeout_limit(mode_reg))
                    begin
                        count_next = '0;
                        ctrl_next  = '0;
                        phase_next = 1'b0;
                        if (!ovf_reg)
                        begin
                            result.nmi_request = 1'b1;
                            ovf_next           = 1'b1;
                        end
                        else
                        begin
                            result.system_reset = 1'b1;
                            ovf_next            = 1'b0;
                            mode_next           = MODE_RESET;
                        end
                    end
                end
            end
            FUNC_WRITE:
            begin
                if (phase_reg && ctrl_reg == KEY_FIRST && item.write_data == KEY_SECOND)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                phase_next = ~phase_reg;
                ctrl_next  = item.write_data;
            end
            FUNC_READ:
            begin
                result.read_data = phase_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ctrl_reg  <= '0;
            phase_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            mode_reg  <= MODE_RESET;
        end
        else if (go)
        begin
            count_reg <= count_next;
            ctrl_reg  <= ctrl_next;
            phase_reg <= phase_next;
            ovf_reg   <= ovf_next;
            mode_reg  <= mode_next;
        end
        else if (cfg_write_en)
        begin
            mode_reg <= cfg_write_data;
        end
    end

endmodule

// ----- sv/wdt2_out_stage.sv -----
// wdt2_out_stage: result register; holds a transaction while the receiver stalls.
// Depends on wdt2_pkg (result_t).
module wdt2_out_stage
    import wdt2_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    stall,
    input  result_t result_in,
    output logic    valid,
    output logic    ready,
    output result_t result_out
);

    logic    valid_reg;
    result_t result_reg;

    assign ready = !valid_reg || !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            result_reg <= result_in;
        end
    end

    assign valid      = valid_reg;
    assign result_out = result_reg;

endmodule

// ----- sv/wdt2_checker.sv -----
// wdt2_checker: port-level assertions for the watchdog core, bound to the top level.
// Depends on watchdog_two_stage_overflow_core port names only.
module wdt2_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic read_data,
    input logic nmi_request,
    input logic system_reset
);

    // Interrupt and reset come from different overflows.
    a_nmi_rst_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(nmi_request && system_reset))
        else $error("nmi_request and system_reset together");

    // Overflow results never carry read data.
    a_ovf_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (nmi_request || system_reset) |-> !read_data)
        else $error("read_data set on overflow result");

    // Input backpressure only comes from a held result.
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("in_stall without output stall");

    // Held transaction stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
            && $stable(nmi_request) && $stable(system_reset))
        else $error("stalled result changed");

endmodule

bind watchdog_two_stage_overflow_core wdt2_checker u_wdt2_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .nmi_request  (nmi_request),
    .system_reset (system_reset)
);
